// File: rtl/mrsfe_pkg.sv
// Package: constants, codes and the CRC-16 byte step for the Modbus RTU slave frame engine.
`default_nettype none
package mrsfe_pkg;
    localparam int RX_BUF_BYTES     = 256;
    localparam int TX_BUF_BYTES     = 256;
    localparam int NUM_HOLDING_REGS = 64;

    localparam int RX_AW  = $clog2(RX_BUF_BYTES);
    localparam int TX_AW  = $clog2(TX_BUF_BYTES);
    localparam int HR_AW  = $clog2(NUM_HOLDING_REGS);
    localparam int LEN_W  = RX_AW + 1;
    localparam int TLEN_W = TX_AW + 1;

    // input command codes
    localparam logic [1:0] CMD_RX_BYTE  = 2'd0;
    localparam logic [1:0] CMD_GAP      = 2'd1;
    localparam logic [1:0] CMD_TX_READY = 2'd2;

    // function and exception codes
    localparam logic [7:0] FC_READ_HOLD   = 8'h03;
    localparam logic [7:0] FC_WRITE_ONE   = 8'h06;
    localparam logic [7:0] FC_WRITE_MULTI = 8'h10;
    localparam logic [7:0] EXC_FLAG       = 8'h80;
    localparam logic [7:0] EXC_ILLEGAL_FC = 8'h01;
    localparam logic [7:0] EXC_BAD_ADDR   = 8'h02;
    localparam logic [7:0] EXC_BAD_VALUE  = 8'h03;

    localparam logic [15:0] MAX_READ_REGS  = 16'd125;
    localparam logic [15:0] MAX_WRITE_REGS = 16'd123;

    // response kinds
    localparam logic [1:0] RSP_EXC  = 2'd0;
    localparam logic [1:0] RSP_READ = 2'd1;
    localparam logic [1:0] RSP_ECHO = 2'd2;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] data);
        logic [15:0] x;
        x = crc ^ {8'h00, data};
        for (int b = 0; b < 8; b++)
        begin
            x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
        end
        return x;
    endfunction
endpackage
`default_nettype wire

// File: rtl/modbus_rtu_slave_frame_engine_core.sv
// Top level: Modbus RTU slave frame engine with receive, transmit and holding-register memories.
//
//  channel  | direction | handshake          | payload
//  s_*      | in        | s_tvalid/s_tready  | s_tuser = command, s_tdata = rx_byte
//  m_*      | out       | m_tvalid/m_tready  | m_tdata = tx_byte, m_tlast = tx_last
//  apb      | in        | psel/penable       | slave_address at byte address 0
//
// A received byte or an ignored command is handled in S_IDLE; a transmitter-ready
// transaction also passes S_TXRD, which loads the registered read of the transmit memory.
// A frame gap runs the accept, receive scan, CRC and checks, then writes received data pairs
// to the registers for a multiple write, then emits the response, reading registers for a read.
// Reset clears lengths, positions and the holding-register valid bits; no clearing pass.
// The input stalls while a frame is processed or a result still waits to be taken.
`default_nettype none
module modbus_rtu_slave_frame_engine_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  wire logic [1:0]  s_tuser,   // [1:0] command
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [7:0] tx_byte
    output logic             m_tlast,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import mrsfe_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_TXRD   = 4'd1;
    localparam logic [3:0] S_SCAN   = 4'd2;
    localparam logic [3:0] S_EVAL   = 4'd3;
    localparam logic [3:0] S_WRMUL  = 4'd4;
    localparam logic [3:0] S_HDR    = 4'd5;
    localparam logic [3:0] S_RDREG  = 4'd6;
    localparam logic [3:0] S_CRC_LO = 4'd7;
    localparam logic [3:0] S_CRC_HI = 4'd8;

    logic [7:0] rx_mem [RX_BUF_BYTES];
    logic [7:0] tx_mem [TX_BUF_BYTES];
    logic [15:0] hr_mem [NUM_HOLDING_REGS];

    logic [3:0]        state_reg, state_next;
    logic [7:0]        addr_reg;
    logic [LEN_W-1:0]  rx_len_reg, rx_len_next;
    logic [TLEN_W-1:0] tx_len_reg, tx_len_next;
    logic [TLEN_W-1:0] tx_pos_reg, tx_pos_next;
    logic [TLEN_W-1:0] wptr_reg, wptr_next;
    logic [15:0]       crc_reg, crc_next;
    logic [15:0]       rcrc_reg, rcrc_next;
    logic [7:0]        h_reg [7];
    logic [7:0]        h_next [7];
    logic [LEN_W-1:0]  iss_reg, iss_next;
    logic [LEN_W-1:0]  didx_reg, didx_next;
    logic              dv_reg, dv_next;
    logic [1:0]        kind_reg, kind_next;
    logic [7:0]        code_reg, code_next;
    logic [2:0]        hcnt_reg, hcnt_next;
    logic [6:0]        k_reg, k_next;
    logic              phase_reg, phase_next;
    logic [7:0]        hold_reg, hold_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [7:0]        m_tdata_reg, m_tdata_next;
    logic              m_tlast_reg, m_tlast_next;
    logic [NUM_HOLDING_REGS-1:0] hr_valid_reg;

    logic [7:0]        rx_q, tx_q;
    logic [15:0]       hr_q;
    logic              hr_qv;
    logic [RX_AW-1:0]  rx_raddr;
    logic              rx_we;
    logic [HR_AW-1:0]  hr_raddr, hr_waddr;
    logic              hr_we;
    logic [15:0]       hr_wdata;
    logic              emit_en, emit_crc;
    logic [7:0]        emit_byte;

    logic              in_acc, pending;
    logic [15:0]       f_start, f_count, hr_data;
    logic [16:0]       f_end, f_count2, f_rdsize;
    logic [LEN_W:0]    f_wmlen;

    assign pready   = 1'b1;
    assign prdata   = {24'h000000, addr_reg};
    assign s_tready = (state_reg == S_IDLE) && (!m_tvalid_reg || m_tready);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign in_acc   = s_tvalid && s_tready;
    assign pending  = tx_pos_reg < tx_len_reg;

    assign f_start  = {h_reg[2], h_reg[3]};
    assign f_count  = {h_reg[4], h_reg[5]};
    assign f_end    = {1'b0, f_start} + {1'b0, f_count};
    assign f_count2 = {f_count, 1'b0};
    assign f_rdsize = f_count2 + 17'd5;
    assign f_wmlen  = {{(LEN_W-7){1'b0}}, h_reg[6]} + (LEN_W+1)'(9);
    assign hr_data  = hr_qv ? hr_q : 16'h0000;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg <= 8'd1;
        end
        else if (psel && penable && pwrite && pready && !paddr[2])
        begin
            addr_reg <= pwdata[7:0];
        end
    end

    // receive memory
    always_ff @(posedge clk)
    begin
        if (rx_we)
        begin
            rx_mem[rx_len_reg[RX_AW-1:0]] <= s_tdata;
        end
        rx_q <= rx_mem[rx_raddr];
    end

    // transmit memory, read always at the current position
    always_ff @(posedge clk)
    begin
        if (emit_en)
        begin
            tx_mem[wptr_reg[TX_AW-1:0]] <= emit_byte;
        end
        tx_q <= tx_mem[tx_pos_reg[TX_AW-1:0]];
    end

    // holding registers; an entry never written reads as zero
    always_ff @(posedge clk)
    begin
        if (hr_we)
        begin
            hr_mem[hr_waddr] <= hr_wdata;
        end
        hr_q <= hr_mem[hr_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hr_valid_reg <= '0;
            hr_qv        <= 1'b0;
        end
        else
        begin
            if (hr_we)
            begin
                hr_valid_reg[hr_waddr] <= 1'b1;
            end
            hr_qv <= hr_valid_reg[hr_raddr];
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        rx_len_next   = rx_len_reg;
        tx_len_next   = tx_len_reg;
        tx_pos_next   = tx_pos_reg;
        wptr_next     = wptr_reg;
        crc_next      = crc_reg;
        rcrc_next     = rcrc_reg;
        h_next        = h_reg;
        iss_next      = iss_reg;
        didx_next     = didx_reg;
        dv_next       = 1'b0;
        kind_next     = kind_reg;
        code_next     = code_reg;
        hcnt_next     = hcnt_reg;
        k_next        = k_reg;
        phase_next    = phase_reg;
        hold_next     = hold_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        rx_we         = 1'b0;
        rx_raddr      = iss_reg[RX_AW-1:0];
        hr_we         = 1'b0;
        hr_waddr      = f_start[HR_AW-1:0];
        hr_wdata      = f_count;
        hr_raddr      = f_start[HR_AW-1:0] + k_reg[HR_AW-1:0];
        emit_en       = 1'b0;
        emit_crc      = 1'b1;
        emit_byte     = addr_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    case (s_tuser)
                        CMD_RX_BYTE:
                        begin
                            if (!pending && (rx_len_reg < LEN_W'(RX_BUF_BYTES)))
                            begin
                                rx_we       = 1'b1;
                                rx_len_next = rx_len_reg + LEN_W'(1);
                            end
                        end
                        CMD_GAP:
                        begin
                            if (!pending && (rx_len_reg != '0))
                            begin
                                iss_next   = '0;
                                crc_next   = CRC_INIT;
                                state_next = S_SCAN;
                            end
                        end
                        CMD_TX_READY:
                        begin
                            if (pending)
                            begin
                                state_next = S_TXRD;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_TXRD:
            begin
                m_tvalid_next = 1'b1;
                m_tdata_next  = tx_q;
                m_tlast_next  = (tx_pos_reg + TLEN_W'(1)) == tx_len_reg;
                tx_pos_next   = tx_pos_reg + TLEN_W'(1);
                state_next    = S_IDLE;
            end

            S_SCAN:
            begin
                // stream the frame: CRC over all but the last two bytes
                if (iss_reg < rx_len_reg)
                begin
                    dv_next   = 1'b1;
                    didx_next = iss_reg;
                    iss_next  = iss_reg + LEN_W'(1);
                end
                if (dv_reg)
                begin
                    if (({1'b0, didx_reg} + (LEN_W+1)'(2)) < {1'b0, rx_len_reg})
                    begin
                        crc_next = crc16_byte(crc_reg, rx_q);
                    end
                    if (({1'b0, didx_reg} + (LEN_W+1)'(2)) == {1'b0, rx_len_reg})
                    begin
                        rcrc_next[7:0] = rx_q;
                    end
                    if (didx_reg < LEN_W'(7))
                    begin
                        h_next[didx_reg[2:0]] = rx_q;
                    end
                    if ((didx_reg + LEN_W'(1)) == rx_len_reg)
                    begin
                        rcrc_next[15:8] = rx_q;
                        state_next      = S_EVAL;
                    end
                end
            end

            S_EVAL:
            begin
                wptr_next  = '0;
                hcnt_next  = '0;
                k_next     = '0;
                phase_next = 1'b0;
                state_next = S_HDR;
                kind_next  = RSP_EXC;
                if ((rx_len_reg < LEN_W'(4)) || (h_reg[0] != addr_reg) ||
                    (crc_reg != rcrc_reg))
                begin
                    rx_len_next = '0;
                    state_next  = S_IDLE;
                end
                else
                begin
                    case (h_reg[1])
                        FC_READ_HOLD:
                        begin
                            if ((rx_len_reg < LEN_W'(8)) || (f_count == 16'd0) ||
                                (f_count > MAX_READ_REGS) ||
                                (f_rdsize > 17'(TX_BUF_BYTES)))
                            begin
                                code_next = EXC_BAD_VALUE;
                            end
                            else if (f_end > 17'(NUM_HOLDING_REGS))
                            begin
                                code_next = EXC_BAD_ADDR;
                            end
                            else
                            begin
                                kind_next = RSP_READ;
                            end
                        end
                        FC_WRITE_ONE:
                        begin
                            if (rx_len_reg < LEN_W'(8))
                            begin
                                code_next = EXC_BAD_VALUE;
                            end
                            else if ({1'b0, f_start} >= 17'(NUM_HOLDING_REGS))
                            begin
                                code_next = EXC_BAD_ADDR;
                            end
                            else
                            begin
                                hr_we     = 1'b1;
                                kind_next = RSP_ECHO;
                            end
                        end
                        FC_WRITE_MULTI:
                        begin
                            if ((rx_len_reg < LEN_W'(9)) || (f_count == 16'd0) ||
                                (f_count > MAX_WRITE_REGS) ||
                                (f_count2 != {9'h000, h_reg[6]}) ||
                                ({1'b0, rx_len_reg} < f_wmlen))
                            begin
                                code_next = EXC_BAD_VALUE;
                            end
                            else if (f_end > 17'(NUM_HOLDING_REGS))
                            begin
                                code_next = EXC_BAD_ADDR;
                            end
                            else
                            begin
                                kind_next  = RSP_ECHO;
                                iss_next   = '0;
                                state_next = S_WRMUL;
                            end
                        end
                        default:
                        begin
                            code_next = EXC_ILLEGAL_FC;
                        end
                    endcase
                end
                crc_next = CRC_INIT;
            end

            S_WRMUL:
            begin
                // fetch data bytes from offset 7, pair them into registers
                rx_raddr = iss_reg[RX_AW-1:0] + RX_AW'(7);
                if (iss_reg < f_count2[LEN_W-1:0])
                begin
                    dv_next   = 1'b1;
                    didx_next = iss_reg;
                    iss_next  = iss_reg + LEN_W'(1);
                end
                if (dv_reg)
                begin
                    if (!didx_reg[0])
                    begin
                        hold_next = rx_q;
                    end
                    else
                    begin
                        hr_we    = 1'b1;
                        hr_waddr = f_start[HR_AW-1:0] + didx_reg[HR_AW:1];
                        hr_wdata = {hold_reg, rx_q};
                    end
                    if ((didx_reg + LEN_W'(1)) == f_count2[LEN_W-1:0])
                    begin
                        state_next = S_HDR;
                    end
                end
            end

            S_HDR:
            begin
                emit_en   = 1'b1;
                hcnt_next = hcnt_reg + 3'd1;
                case (hcnt_reg)
                    3'd0: emit_byte = addr_reg;
                    3'd1:
                    begin
                        case (kind_reg)
                            RSP_EXC:  emit_byte = h_reg[1] | EXC_FLAG;
                            RSP_READ: emit_byte = FC_READ_HOLD;
                            default:  emit_byte = h_reg[1];
                        endcase
                    end
                    3'd2:
                    begin
                        case (kind_reg)
                            RSP_EXC:  emit_byte = code_reg;
                            RSP_READ: emit_byte = f_count2[7:0];
                            default:  emit_byte = h_reg[2];
                        endcase
                    end
                    3'd3: emit_byte = h_reg[3];
                    3'd4: emit_byte = h_reg[4];
                    default: emit_byte = h_reg[5];
                endcase
                if ((kind_reg != RSP_ECHO) && (hcnt_reg == 3'd2))
                begin
                    state_next = (kind_reg == RSP_READ) ? S_RDREG : S_CRC_LO;
                end
                else if (hcnt_reg == 3'd5)
                begin
                    state_next = S_CRC_LO;
                end
            end

            S_RDREG:
            begin
                if (!phase_reg)
                begin
                    emit_byte = hold_reg;
                    if (k_reg == f_count[6:0])
                    begin
                        emit_en    = 1'b1;
                        state_next = S_CRC_LO;
                    end
                    else
                    begin
                        emit_en    = (k_reg != 7'd0);
                        phase_next = 1'b1;
                    end
                end
                else
                begin
                    emit_en    = 1'b1;
                    emit_byte  = hr_data[15:8];
                    hold_next  = hr_data[7:0];
                    k_next     = k_reg + 7'd1;
                    phase_next = 1'b0;
                end
            end

            S_CRC_LO:
            begin
                emit_en   = 1'b1;
                emit_crc  = 1'b0;
                emit_byte = crc_reg[7:0];
            end

            S_CRC_HI:
            begin
                emit_en     = 1'b1;
                emit_crc    = 1'b0;
                emit_byte   = crc_reg[15:8];
                tx_len_next = wptr_reg + TLEN_W'(1);
                tx_pos_next = '0;
                rx_len_next = '0;
                state_next  = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (state_reg == S_CRC_LO)
        begin
            state_next = S_CRC_HI;
        end
        if (emit_en)
        begin
            wptr_next = wptr_reg + TLEN_W'(1);
            if (emit_crc)
            begin
                crc_next = crc16_byte(crc_reg, emit_byte);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            rx_len_reg   <= '0;
            tx_len_reg   <= '0;
            tx_pos_reg   <= '0;
            dv_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            rx_len_reg   <= rx_len_next;
            tx_len_reg   <= tx_len_next;
            tx_pos_reg   <= tx_pos_next;
            dv_reg       <= dv_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        wptr_reg    <= wptr_next;
        crc_reg     <= crc_next;
        rcrc_reg    <= rcrc_next;
        h_reg       <= h_next;
        iss_reg     <= iss_next;
        didx_reg    <= didx_next;
        kind_reg    <= kind_next;
        code_reg    <= code_next;
        hcnt_reg    <= hcnt_next;
        k_reg       <= k_next;
        phase_reg   <= phase_next;
        hold_reg    <= hold_next;
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

`ifndef ASSERT_OFF
    a_out_from_txrd: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> $past(state_reg) == S_TXRD)
        else $error("result raised outside transmit read");
    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        tx_pos_reg <= tx_len_reg)
        else $error("transmit position beyond length");
    a_eval_idle_tx: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EVAL) |-> (tx_pos_reg == tx_len_reg) && (rx_len_reg != '0))
        else $error("frame evaluated while a response is pending");
    a_crc_pair: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CRC_LO) |=> state_reg == S_CRC_HI)
        else $error("CRC bytes not emitted in pair");
`endif
endmodule
`default_nettype wire

// File: tb/modbus_rtu_slave_frame_engine_core_tb.sv
// Testbench: Modbus RTU slave frame engine, random frames checked against a behavioral predictor.
`default_nettype none
module modbus_rtu_slave_frame_engine_core_tb;
    import mrsfe_pkg::*;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] rx_byte;
    } rx_item_t;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       tx_last;
    } tx_item_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] rx_byte
    logic [1:0]  s_tuser;   // [1:0] command
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // [7:0] tx_byte
    logic        m_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    modbus_rtu_slave_frame_engine_core uut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // predictor state
    logic [7:0]  own_addr;
    logic [7:0]  frame_buf [RX_BUF_BYTES];
    int          frame_len;
    logic [7:0]  reply_buf [TX_BUF_BYTES + 2];
    int          reply_len;
    int          reply_pos;
    logic [15:0] regs [NUM_HOLDING_REGS];

    rx_item_t    pending_items[$];
    tx_item_t    expected_bytes[$];
    int          errors;
    int          sent_items;
    int          got_bytes;
    int          ex_frames;
    bit          hold_sender;
    int          send_wait;
    int          take_wait;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic [15:0] crc_of(input logic [7:0] b[$]);
        logic [15:0] c;
        c = 16'hFFFF;
        foreach (b[i])
        begin
            c ^= {8'h00, b[i]};
            for (int k = 0; k < 8; k++)
                c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
        end
        return c;
    endfunction

    function automatic void seal_reply(input int n);
        logic [7:0]  q[$];
        logic [15:0] c;
        for (int i = 0; i < n; i++)
            q.push_back(reply_buf[i]);
        c = crc_of(q);
        reply_buf[n] = c[7:0];
        reply_buf[n + 1] = c[15:8];
        reply_len = n + 2;
        reply_pos = 0;
    endfunction

    function automatic void raise_exception(input logic [7:0] fc, input logic [7:0] code);
        reply_buf[0] = own_addr;
        reply_buf[1] = fc | EXC_FLAG;
        reply_buf[2] = code;
        ex_frames++;
        seal_reply(3);
    endfunction

    function automatic int word_at(input int p);
        return {frame_buf[p], frame_buf[p + 1]};
    endfunction

    function automatic void serve_frame();
        logic [7:0]  q[$];
        logic [15:0] c;
        int n, start, count, nbytes, idx;
        n = frame_len;
        if (n < 4 || frame_buf[0] != own_addr)
            return;
        for (int i = 0; i < n - 2; i++)
            q.push_back(frame_buf[i]);
        c = crc_of(q);
        if (c != {frame_buf[n - 1], frame_buf[n - 2]})
            return;
        case (frame_buf[1])
            FC_READ_HOLD:
            begin
                if (n < 8)
                begin
                    raise_exception(FC_READ_HOLD, EXC_BAD_VALUE);
                    return;
                end
                start = word_at(2);
                count = word_at(4);
                if (count == 0 || count > MAX_READ_REGS || 5 + 2 * count > TX_BUF_BYTES)
                    raise_exception(FC_READ_HOLD, EXC_BAD_VALUE);
                else if (start + count > NUM_HOLDING_REGS)
                    raise_exception(FC_READ_HOLD, EXC_BAD_ADDR);
                else
                begin
                    reply_buf[0] = own_addr;
                    reply_buf[1] = FC_READ_HOLD;
                    reply_buf[2] = 8'(count * 2);
                    idx = 3;
                    for (int i = 0; i < count; i++)
                    begin
                        reply_buf[idx] = regs[start + i][15:8];
                        reply_buf[idx + 1] = regs[start + i][7:0];
                        idx += 2;
                    end
                    seal_reply(idx);
                end
            end
            FC_WRITE_ONE:
            begin
                if (n < 8)
                begin
                    raise_exception(FC_WRITE_ONE, EXC_BAD_VALUE);
                    return;
                end
                start = word_at(2);
                if (start >= NUM_HOLDING_REGS)
                    raise_exception(FC_WRITE_ONE, EXC_BAD_ADDR);
                else
                begin
                    regs[start] = 16'(word_at(4));
                    for (int i = 0; i < 6; i++)
                        reply_buf[i] = frame_buf[i];
                    reply_buf[0] = own_addr;
                    seal_reply(6);
                end
            end
            FC_WRITE_MULTI:
            begin
                if (n < 9)
                begin
                    raise_exception(FC_WRITE_MULTI, EXC_BAD_VALUE);
                    return;
                end
                start = word_at(2);
                count = word_at(4);
                nbytes = frame_buf[6];
                if (count == 0 || count > MAX_WRITE_REGS || nbytes != 2 * count
                    || n < 9 + nbytes)
                    raise_exception(FC_WRITE_MULTI, EXC_BAD_VALUE);
                else if (start + count > NUM_HOLDING_REGS)
                    raise_exception(FC_WRITE_MULTI, EXC_BAD_ADDR);
                else
                begin
                    for (int i = 0; i < count; i++)
                        regs[start + i] = 16'(word_at(7 + 2 * i));
                    for (int i = 0; i < 6; i++)
                        reply_buf[i] = frame_buf[i];
                    reply_buf[0] = own_addr;
                    seal_reply(6);
                end
            end
            default:
                raise_exception(frame_buf[1], EXC_ILLEGAL_FC);
        endcase
    endfunction

    function automatic void predict_item(input rx_item_t it);
        bit busy;
        tx_item_t r;
        busy = reply_pos < reply_len;
        case (it.command)
            CMD_RX_BYTE:
                if (!busy && frame_len < RX_BUF_BYTES)
                begin
                    frame_buf[frame_len] = it.rx_byte;
                    frame_len++;
                end
            CMD_GAP:
                if (!busy && frame_len > 0)
                begin
                    serve_frame();
                    frame_len = 0;
                end
            CMD_TX_READY:
                if (busy)
                begin
                    r.tx_byte = reply_buf[reply_pos];
                    r.tx_last = (reply_pos + 1 == reply_len);
                    reply_pos++;
                    expected_bytes.push_back(r);
                end
            default:;
        endcase
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= 8'h00;
            s_tuser <= 2'd0;
            send_wait <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                predict_item(rx_item_t'({s_tuser, s_tdata}));
                sent_items++;
            end
            if (s_tvalid && !s_tready)
                ;
            else if (send_wait > 0)
            begin
                s_tvalid <= 1'b0;
                send_wait <= send_wait - 1;
            end
            else if (pending_items.size() > 0 && !hold_sender)
            begin
                rx_item_t it;
                it = pending_items.pop_front();
                s_tvalid <= 1'b1;
                s_tuser <= it.command;
                s_tdata <= it.rx_byte;
                send_wait <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            take_wait <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                tx_item_t e;
                got_bytes++;
                if (expected_bytes.size() == 0)
                begin
                    $error("unexpected tx_byte %h", m_tdata);
                    errors++;
                end
                else
                begin
                    e = expected_bytes.pop_front();
                    if (m_tdata !== e.tx_byte)
                    begin
                        $error("tx_byte expected %h actual %h", e.tx_byte, m_tdata);
                        errors++;
                    end
                    if (m_tlast !== e.tx_last)
                    begin
                        $error("tx_last expected %b actual %b", e.tx_last, m_tlast);
                        errors++;
                    end
                end
            end
            if (take_wait > 0)
            begin
                m_tready <= 1'b0;
                take_wait <= take_wait - 1;
            end
            else
            begin
                m_tready <= 1'b1;
                if (m_tvalid && m_tready)
                    take_wait <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
            end
        end
    end

    task automatic add_item(input logic [1:0] cmd, input logic [7:0] b);
        rx_item_t it;
        it.command = cmd;
        it.rx_byte = b;
        pending_items.push_back(it);
    endtask

    // queue a frame with CRC (optionally corrupted), end it with a gap, then twelve transmitter-ready commands
    task automatic add_frame(input logic [7:0] body[$], input bit bad_crc);
        logic [15:0] c;
        c = crc_of(body);
        if (bad_crc)
            c ^= 16'h0001 << $urandom_range(0, 15);
        foreach (body[i])
            add_item(CMD_RX_BYTE, body[i]);
        add_item(CMD_RX_BYTE, c[7:0]);
        add_item(CMD_RX_BYTE, c[15:8]);
        add_item(CMD_GAP, 8'($urandom_range(0, 255)));
        for (int i = 0; i < 12; i++)
            add_item(CMD_TX_READY, 8'($urandom_range(0, 255)));
    endtask

    task automatic wait_idle();
        while (pending_items.size() > 0 || s_tvalid || expected_bytes.size() > 0)
            @(posedge clk);
        repeat (600) @(posedge clk);
    endtask

    task automatic apb_write(input logic [2:0] a, input logic [31:0] d);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= a;
        pwdata <= d;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_address(input logic [7:0] a);
        apb_write(3'd0, {24'h0, a});
        own_addr = a;
    endtask

    task automatic rand_request(input bit tidy);
        logic [7:0] b[$];
        int count, start, sel;
        sel = $urandom_range(0, 9);
        b.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : own_addr);
        count = tidy ? $urandom_range(1, 6) : $urandom_range(0, 130);
        start = tidy ? $urandom_range(0, NUM_HOLDING_REGS - count) : $urandom_range(0, 70);
        if ($urandom_range(0, 15) == 0)
            start = $urandom_range(0, 65535);
        if (sel < 3)
        begin
            b.push_back(FC_READ_HOLD);
            b.push_back(8'(start >> 8)); b.push_back(8'(start));
            b.push_back(8'(count >> 8)); b.push_back(8'(count));
        end
        else if (sel < 6)
        begin
            b.push_back(FC_WRITE_ONE);
            b.push_back(8'(start >> 8)); b.push_back(8'(start));
            b.push_back(8'($urandom_range(0, 255))); b.push_back(8'($urandom_range(0, 255)));
        end
        else if (sel < 9)
        begin
            if (count > 8 && tidy)
                count = 8;
            b.push_back(FC_WRITE_MULTI);
            b.push_back(8'(start >> 8)); b.push_back(8'(start));
            b.push_back(8'(count >> 8)); b.push_back(8'(count));
            b.push_back(($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255)) : 8'(2 * count));
            for (int i = 0; i < 2 * (count > 8 ? 8 : count); i++)
                b.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            b.push_back(8'($urandom_range(0, 255)));
            for (int i = 0; i < $urandom_range(0, 5); i++)
                b.push_back(8'($urandom_range(0, 255)));
        end
        if (!tidy && $urandom_range(0, 3) == 0 && b.size() > 2)
            b = b[0:$urandom_range(0, b.size() - 1)];
        add_frame(b, !tidy && $urandom_range(0, 5) == 0);
    endtask

    initial
    begin
        logic [7:0] f[$];
        int budget;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = 3'd0;
        pwdata = 32'd0;
        errors = 0;
        sent_items = 0;
        got_bytes = 0;
        ex_frames = 0;
        hold_sender = 1'b0;
        own_addr = 8'd1;
        frame_len = 0;
        reply_len = 0;
        reply_pos = 0;
        foreach (regs[i])
            regs[i] = 16'h0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset address, each function, exceptions, drops, odd commands
        add_item(CMD_TX_READY, 8'h00);
        add_item(2'd3, 8'hFF);
        add_item(CMD_GAP, 8'h00);
        f = '{8'h01, FC_WRITE_ONE, 8'h00, 8'h3F, 8'hFF, 8'hFF};
        add_frame(f, 1'b0);
        f = '{8'h01, FC_READ_HOLD, 8'h00, 8'h3E, 8'h00, 8'h02};
        add_frame(f, 1'b0);
        f = '{8'h01, FC_READ_HOLD, 8'h00, 8'h00, 8'h00, 8'd126};
        add_frame(f, 1'b0);
        f = '{8'h01, FC_WRITE_MULTI, 8'h00, 8'h3F, 8'h00, 8'h02, 8'h04,
              8'h12, 8'h34, 8'h56, 8'h78};
        add_frame(f, 1'b0);
        f = '{8'h01, 8'h7F};
        add_frame(f, 1'b0);
        add_frame(f, 1'b1);
        wait_idle();

        set_address(8'd247);
        f = '{8'd247, FC_READ_HOLD, 8'h00, 8'h00, 8'h00, 8'h40};
        add_frame(f, 1'b0);
        f = '{8'd247, FC_WRITE_ONE, 8'hFF, 8'hFF};
        add_frame(f, 1'b0);
        add_item(CMD_RX_BYTE, 8'd247);
        add_item(CMD_GAP, 8'h00);
        // overflow the receive buffer
        for (int i = 0; i < RX_BUF_BYTES + 4; i++)
            add_item(CMD_RX_BYTE, 8'($urandom_range(0, 255)));
        add_item(CMD_GAP, 8'h00);
        wait_idle();

        // random part over several addresses; in phase 2 the sender pauses until drained whenever over 20 items wait
        for (int phase = 0; phase < 4; phase++)
        begin
            if (phase > 0)
            begin
                wait_idle();
                set_address(phase == 1 ? 8'd1 : phase == 2 ? 8'd128 : 8'($urandom_range(1, 247)));
            end
            budget = sent_items + pending_items.size() + 25;
            while (sent_items + pending_items.size() < budget)
            begin
                if ($urandom_range(0, 19) == 0)
                    add_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
                else
                    rand_request($urandom_range(0, 3) != 0);
                if (phase == 2 && pending_items.size() > 20)
                begin
                    hold_sender = 1'b1;
                    wait (expected_bytes.size() == 0 && !s_tvalid);
                    hold_sender = 1'b0;
                end
                while (pending_items.size() > 200)
                    @(posedge clk);
            end
        end
        wait_idle();

        $display("covered %0d input transactions, %0d response bytes, %0d exception replies",
                 sent_items, got_bytes, ex_frames);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #50000000;
        $display("tb: failure");
        $finish;
    end
endmodule
`default_nettype wire
